@@ rtl/core/zps_pkg.sv @@
package zps_pkg;

  localparam int unsigned Threads    = 8;
  localparam int unsigned StackDepth = 64;
  localparam int unsigned Callsites  = 256;

  localparam int unsigned ThW   = 3;
  localparam int unsigned SiteW = 8;
  localparam int unsigned TsW   = 63;
  localparam int unsigned LvlW  = $clog2(StackDepth + 1);
  localparam int unsigned TopW  = $clog2(StackDepth);
  localparam int unsigned CsW   = $clog2(Callsites);
  localparam int unsigned StkAw = $clog2(Threads * StackDepth);
  localparam int unsigned ExcW  = 16;
  localparam int unsigned CntW  = 32;
  localparam int unsigned TotW  = 64;

  localparam int unsigned InW  = 1 + ThW + SiteW + TsW;
  localparam int unsigned InTdW = ((InW + 7) / 8) * 8;
  localparam int unsigned OutW = 3 + 8 + 6 + 63 * 3 + 64 * 2 + 63 * 2 + 32;
  localparam int unsigned OutTdW = ((OutW + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_STAT,
    ST_CALC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic do_event;
    logic do_stat;
    logic do_update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic pop_valid;
  } sts_t;

endpackage

@@ rtl/core/zps_ctrl.sv @@
module zps_ctrl
  import zps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.do_event = 1'b1;
        state_d = sts_i.pop_valid ? ST_STAT : ST_IDLE;
      end
      ST_STAT: begin
        cmd_o.do_stat = 1'b1;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.do_update = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load_in = 1'b1;
            state_d = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/core/zps_dp.sv @@
module zps_dp
  import zps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [InW-1:0]    in_data_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [OutW-1:0]   rec_o
);

  logic [TsW-1:0]   stk_start [Threads*StackDepth];
  logic [CsW-1:0]   stk_site  [Threads*StackDepth];
  logic [TsW-1:0]   stk_child [Threads*StackDepth];
  logic [TotW-1:0]  s_tinc [Callsites];
  logic [TotW-1:0]  s_tslf [Callsites];
  logic [TsW-1:0]   s_minc [Callsites];
  logic [TsW-1:0]   s_mslf [Callsites];
  logic [CntW-1:0]  s_cnt  [Callsites];

  logic [LvlW-1:0] lvl_q [Threads];
  logic [ExcW-1:0] exc_q [Threads];

  logic             kind_q;
  logic [ThW-1:0]   th_q;
  logic [SiteW-1:0] site_q;
  logic [TsW-1:0]   ts_q;

  logic [CsW:0]     clr_q;
  logic [TopW-1:0]  top_q;
  logic [StkAw-1:0] par_q;
  logic             has_par_q;
  logic [TsW-1:0]   start_q, child_q, pchild_q;
  logic [CsW-1:0]   cs_q;
  logic [TotW-1:0]  tinc_q, tslf_q;
  logic [TsW-1:0]   minc_q, mslf_q, incl_q;
  logic [CntW-1:0]  cnt_q;
  logic [OutW-1:0]  rec_q;

  logic             th_ok;
  logic [LvlW-1:0]  lvl;
  logic [ExcW-1:0]  exc;
  logic [StkAw-1:0] push_a, top_a;
  logic [LvlW-1:0]  lvl_m1;
  logic             pop;

  logic [TsW-1:0]   incl, self;
  logic [TsW:0]     csum;
  logic [TotW-1:0]  ntinc, ntslf;
  logic [TsW-1:0]   nminc, nmslf;
  logic [CntW-1:0]  ncnt;

  assign th_ok  = (32'(th_q) < Threads);
  assign lvl    = lvl_q[th_q];
  assign exc    = exc_q[th_q];
  assign lvl_m1 = lvl - LvlW'(1);
  assign push_a = StkAw'(32'(th_q) * StackDepth + 32'(lvl));
  assign top_a  = StkAw'(32'(th_q) * StackDepth + 32'(lvl_m1));
  assign pop    = th_ok && kind_q && (exc == '0) && (lvl != '0);
  assign sts_o.pop_valid = pop;
  assign sts_o.clr_done  = (clr_q == (CsW+1)'(Callsites - 1));

  assign incl  = (ts_q >= start_q) ? ts_q - start_q : '0;
  assign self  = (incl_q >= child_q) ? incl_q - child_q : '0;
  assign csum  = {1'b0, pchild_q} + {1'b0, incl_q};
  assign ntinc = tinc_q + TotW'(incl_q);
  assign ntslf = tslf_q + TotW'(self);
  assign nminc = (incl_q > minc_q) ? incl_q : minc_q;
  assign nmslf = (self > mslf_q) ? self : mslf_q;
  assign ncnt  = (cnt_q != '1) ? cnt_q + CntW'(1) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      for (int i = 0; i < Threads; i++) begin
        lvl_q[i] <= '0;
        exc_q[i] <= '0;
      end
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.do_event && th_ok) begin
        if (!kind_q) begin
          if (32'(lvl) >= StackDepth) begin
            if (exc != '1) exc_q[th_q] <= exc + 1'b1;
          end else begin
            lvl_q[th_q] <= lvl + 1'b1;
          end
        end else if (exc != '0) begin
          exc_q[th_q] <= exc - 1'b1;
        end else if (lvl != '0) begin
          lvl_q[th_q] <= lvl_m1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      {ts_q, site_q, th_q, kind_q} <= in_data_i;
    end
    if (cmd_i.clr_step) begin
      s_tinc[clr_q[CsW-1:0]] <= '0;
      s_tslf[clr_q[CsW-1:0]] <= '0;
      s_minc[clr_q[CsW-1:0]] <= '0;
      s_mslf[clr_q[CsW-1:0]] <= '0;
      s_cnt[clr_q[CsW-1:0]]  <= '0;
    end
    if (cmd_i.do_event) begin
      if (th_ok && !kind_q && 32'(lvl) < StackDepth) begin
        stk_start[push_a] <= ts_q;
        stk_site[push_a]  <= CsW'(32'(site_q) % Callsites);
        stk_child[push_a] <= '0;
      end
      start_q   <= stk_start[top_a];
      child_q   <= stk_child[top_a];
      cs_q      <= stk_site[top_a];
      pchild_q  <= stk_child[top_a - StkAw'(1)];
      par_q     <= top_a - StkAw'(1);
      has_par_q <= (lvl_m1 != '0);
      top_q     <= TopW'(lvl_m1);
    end
    if (cmd_i.do_stat) begin
      tinc_q <= s_tinc[cs_q];
      tslf_q <= s_tslf[cs_q];
      minc_q <= s_minc[cs_q];
      mslf_q <= s_mslf[cs_q];
      cnt_q  <= s_cnt[cs_q];
      incl_q <= incl;
    end
    if (cmd_i.do_update) begin
      if (has_par_q) stk_child[par_q] <= csum[TsW] ? '1 : csum[TsW-1:0];
      s_tinc[cs_q] <= ntinc;
      s_tslf[cs_q] <= ntslf;
      s_minc[cs_q] <= nminc;
      s_mslf[cs_q] <= nmslf;
      s_cnt[cs_q]  <= ncnt;
      rec_q <= {ncnt, nmslf, nminc, ntslf, ntinc, self, incl_q, start_q,
                6'(top_q), 8'(cs_q), th_q};
    end
  end

  assign rec_o = rec_q;

endmodule

@@ rtl/core/zone_profiler_stack_stats.sv @@
// Channel  Dir  tdata fields (low bit first)                              tuser
// s_axis   in   thread_id, callsite, timestamp                            kind
// m_axis   out  rec_thread, rec_callsite, rec_depth, start_time,
//               inclusive_time, self_time, total_inclusive, total_self,
//               max_inclusive, max_self, call_count                       -
// An event without a record is accepted, then the stack is accessed; a
// completed zone goes through stack read, statistics read, clamp and
// update, and output, and then waits for the output to be taken. After
// reset all 256 statistics entries are cleared before the first
// request is taken. A stalled result holds the block; the next request
// is taken in the cycle the result leaves.
module zone_profiler_stack_stats
  import zps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InTdW-1:0]    s_axis_tdata,  // thread_id, callsite, timestamp
  input  logic                s_axis_tuser,  // kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutTdW-1:0]   m_axis_tdata   // see table above
);

  cmd_t cmd;
  sts_t sts;
  logic [OutW-1:0] rec;

  zps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  zps_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i ({s_axis_tdata[InW-2:0], s_axis_tuser}),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .rec_o     (rec)
  );

  assign m_axis_tdata = OutTdW'(rec);

endmodule
